// ===== rtl/core/rorl_pkg.sv =====
// Package with the shared widths, codes and item types of the record ring.
package rorl_pkg;

  // Default sizing of the ring.
  localparam int SLOTS_DEF        = 16;
  localparam int HANDLE_WIDTH_DEF = 32;
  localparam int LENGTH_WIDTH_DEF = 16;

  // Fixed widths of the channel fields.
  localparam int KIND_W        = 1;
  localparam int HANDLE_PORT_W = 32;
  localparam int LENGTH_PORT_W = 16;
  localparam int OFFSET_W      = 20;
  localparam int STATUS_W      = 2;
  localparam int SLOT_PORT_W   = 4;
  localparam int IN_REC_W      = 16;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_ADD  = 1'b0;
  localparam logic [KIND_W-1:0] KIND_FIND = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REJECT    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [HANDLE_PORT_W-1:0] new_handle;
    logic [LENGTH_PORT_W-1:0] new_length;
    logic [OFFSET_W-1:0]      byte_offset;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic                     evicted;
    logic [HANDLE_PORT_W-1:0] evicted_handle;
    logic [HANDLE_PORT_W-1:0] found_handle;
    logic [LENGTH_PORT_W-1:0] found_length;
    logic [SLOT_PORT_W-1:0]   found_slot;
    logic [IN_REC_W-1:0]      offset_in_record;
  } res_t;

endpackage

// ===== rtl/core/rorl_chan_if.sv =====
// Valid/ready channel interfaces for the items and the results of the record ring.
interface rorl_in_if;
  import rorl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [HANDLE_PORT_W-1:0] new_handle;
  logic [LENGTH_PORT_W-1:0] new_length;
  logic [OFFSET_W-1:0]      byte_offset;

  modport source (output valid, kind, new_handle, new_length, byte_offset, input ready);
  modport sink (input valid, kind, new_handle, new_length, byte_offset, output ready);
endinterface

interface rorl_out_if;
  import rorl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic                     evicted;
  logic [HANDLE_PORT_W-1:0] evicted_handle;
  logic [HANDLE_PORT_W-1:0] found_handle;
  logic [LENGTH_PORT_W-1:0] found_length;
  logic [SLOT_PORT_W-1:0]   found_slot;
  logic [IN_REC_W-1:0]      offset_in_record;

  modport source (output valid, status, evicted, evicted_handle, found_handle, found_length,
                  found_slot, offset_in_record, input ready);
  modport sink (input valid, status, evicted, evicted_handle, found_handle, found_length,
                found_slot, offset_in_record, output ready);
endinterface

// ===== rtl/core/ring_of_records_with_offset_lookup_unit.sv =====
// Top level of the record ring with offset lookup: memory, sequencer, output register.
//
// Usage: items arrive on in_ch, one result per item leaves on out_ch; both are
// valid/ready channels and a transfer happens when valid and ready are high at a
// rising edge of clk. An add (kind 0) stores a handle/length record, overwriting
// and reporting the oldest one when the ring is full; a zero handle or length is
// rejected. A find (kind 1) locates a byte offset across the stored records,
// oldest first.
// Sequence: an add moves from idle to the add state, where its result enters the output
// register once that register is free, and the sequencer then returns to idle.
// A find reads one record per cycle from the record memory until it reaches the
// record that holds the offset or has walked every stored record; its result is
// then registered once the output register is free. One item is worked on at a time;
// in_ch.ready is high whenever the sequencer is idle.
// Stalls: the result sits in an output register, so the next item is taken while
// it waits; a finished item then holds until out_ch takes the earlier result.
// Reset: rst_n is synchronous and active low; it empties the ring and the output
// register. Record contents are not cleared and are never read before written.
module ring_of_records_with_offset_lookup_unit #(
  parameter int SLOTS        = rorl_pkg::SLOTS_DEF,
  parameter int HANDLE_WIDTH = rorl_pkg::HANDLE_WIDTH_DEF,
  parameter int LENGTH_WIDTH = rorl_pkg::LENGTH_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rorl_in_if.sink     in_ch,
  rorl_out_if.source  out_ch
);
  import rorl_pkg::*;

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int WORD_W = HANDLE_WIDTH + LENGTH_WIDTH;

  item_t             item;
  res_t              res;
  res_t              out_r;
  logic              out_valid_r;
  logic              out_free;
  logic              res_valid;
  logic              in_ready;
  logic              mem_we;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_waddr;
  logic [IDX_W-1:0]  mem_raddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;

  assign item.kind        = in_ch.kind;
  assign item.new_handle  = in_ch.new_handle;
  assign item.new_length  = in_ch.new_length;
  assign item.byte_offset = in_ch.byte_offset;
  assign in_ch.ready      = in_ready;

  assign out_free = !out_valid_r || out_ch.ready;

  rorl_ring_mem #(
    .DEPTH (SLOTS),
    .WIDTH (WORD_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rorl_seq #(
    .SLOTS        (SLOTS),
    .HANDLE_WIDTH (HANDLE_WIDTH),
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .item      (item),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = out_r.status;
  assign out_ch.evicted          = out_r.evicted;
  assign out_ch.evicted_handle   = out_r.evicted_handle;
  assign out_ch.found_handle     = out_r.found_handle;
  assign out_ch.found_length     = out_r.found_length;
  assign out_ch.found_slot       = out_r.found_slot;
  assign out_ch.offset_in_record = out_r.offset_in_record;

endmodule

// ===== rtl/core/rorl_ring_mem.sv =====
// Record memory: one write port and one read port with registered read data.
module rorl_ring_mem #(
  parameter int DEPTH = rorl_pkg::SLOTS_DEF,
  parameter int WIDTH = rorl_pkg::HANDLE_WIDTH_DEF + rorl_pkg::LENGTH_WIDTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/rorl_seq.sv =====
// Sequencer: ring indices, add read-modify-write and the slot-by-slot offset walk.
module rorl_seq #(
  parameter int SLOTS        = rorl_pkg::SLOTS_DEF,
  parameter int HANDLE_WIDTH = rorl_pkg::HANDLE_WIDTH_DEF,
  parameter int LENGTH_WIDTH = rorl_pkg::LENGTH_WIDTH_DEF,
  localparam int IDX_W  = $clog2(SLOTS),
  localparam int WORD_W = HANDLE_WIDTH + LENGTH_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rorl_pkg::item_t     item,
  input  logic                out_free,
  output logic                res_valid,
  output rorl_pkg::res_t      res,
  output logic                mem_we,
  output logic [IDX_W-1:0]    mem_waddr,
  output logic [WORD_W-1:0]   mem_wdata,
  output logic                mem_re,
  output logic [IDX_W-1:0]    mem_raddr,
  input  logic [WORD_W-1:0]   mem_rdata
);
  import rorl_pkg::*;

  localparam int CNT_W = IDX_W + 1;
  localparam int OFF_W = (LENGTH_WIDTH > OFFSET_W) ? LENGTH_WIDTH : OFFSET_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADD  = 2'd1;
  localparam logic [1:0] S_FIND = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [IDX_W-1:0]        wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic                    full_r, full_nxt;
  logic [HANDLE_WIDTH-1:0] h_r, h_nxt;
  logic [LENGTH_WIDTH-1:0] len_r, len_nxt;
  logic [OFF_W-1:0]        off_r, off_nxt;
  logic [IDX_W-1:0]        p_r, p_nxt;
  logic [CNT_W-1:0]        remain_r, remain_nxt;

  logic [HANDLE_WIDTH-1:0] rd_handle;
  logic [LENGTH_WIDTH-1:0] rd_len;
  logic [OFF_W-1:0]        rd_len_ext;
  logic [IDX_W-1:0]        wr_next, rd_next, p_next;
  logic [CNT_W-1:0]        count;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(SLOTS - 1)) ? '0 : i + 1'b1;
  endfunction

  assign rd_handle  = mem_rdata[WORD_W-1:LENGTH_WIDTH];
  assign rd_len     = mem_rdata[LENGTH_WIDTH-1:0];
  assign rd_len_ext = OFF_W'(rd_len);
  assign wr_next    = next_idx(wr_idx_r);
  assign rd_next    = next_idx(rd_idx_r);
  assign p_next     = next_idx(p_r);

  // Stored record count; a full ring has equal indices and holds every slot.
  always_comb begin
    if (full_r) begin
      count = CNT_W'(SLOTS);
    end else if (wr_idx_r >= rd_idx_r) begin
      count = CNT_W'(wr_idx_r) - CNT_W'(rd_idx_r);
    end else begin
      count = CNT_W'(wr_idx_r) + CNT_W'(SLOTS) - CNT_W'(rd_idx_r);
    end
  end

  assign in_ready = (state_r == S_IDLE);

  // The only write happens in the add state, as it returns to idle, so the next
  // read is issued later from idle and sees the written record.
  always_comb begin
    state_nxt  = state_r;
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    full_nxt   = full_r;
    h_nxt      = h_r;
    len_nxt    = len_r;
    off_nxt    = off_r;
    p_nxt      = p_r;
    remain_nxt = remain_r;
    mem_re     = 1'b0;
    mem_raddr  = wr_idx_r;
    mem_we     = 1'b0;
    mem_waddr  = wr_idx_r;
    mem_wdata  = {h_r, len_r};
    res_valid  = 1'b0;
    res        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          h_nxt      = HANDLE_WIDTH'(item.new_handle);
          len_nxt    = LENGTH_WIDTH'(item.new_length);
          off_nxt    = OFF_W'(item.byte_offset);
          p_nxt      = rd_idx_r;
          remain_nxt = count;
          mem_re     = 1'b1;
          if (item.kind == KIND_ADD) begin
            mem_raddr = wr_idx_r;
            state_nxt = S_ADD;
          end else begin
            mem_raddr = rd_idx_r;
            state_nxt = S_FIND;
          end
        end
      end
      S_ADD: begin
        if (out_free) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
          if (h_r == '0 || len_r == '0) begin
            res.status = STATUS_REJECT;
          end else begin
            res.status = STATUS_DONE;
            mem_we     = 1'b1;
            wr_idx_nxt = wr_next;
            if (full_r) begin
              res.evicted        = 1'b1;
              res.evicted_handle = HANDLE_PORT_W'(rd_handle);
              rd_idx_nxt         = rd_next;
            end
            full_nxt = (wr_next == (full_r ? rd_next : rd_idx_r));
          end
        end
      end
      S_FIND: begin
        if (remain_r == '0) begin
          if (out_free) begin
            res_valid  = 1'b1;
            res.status = STATUS_NOT_FOUND;
            state_nxt  = S_IDLE;
          end
        end else if (off_r < rd_len_ext) begin
          if (out_free) begin
            res_valid            = 1'b1;
            res.status           = STATUS_DONE;
            res.found_handle     = HANDLE_PORT_W'(rd_handle);
            res.found_length     = LENGTH_PORT_W'(rd_len);
            res.found_slot       = SLOT_PORT_W'(p_r);
            res.offset_in_record = IN_REC_W'(off_r);
            state_nxt            = S_IDLE;
          end
        end else begin
          // Skip this record and fetch the next slot for the following cycle.
          off_nxt    = off_r - rd_len_ext;
          remain_nxt = remain_r - 1'b1;
          p_nxt      = p_next;
          mem_re     = 1'b1;
          mem_raddr  = p_next;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      full_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      full_r   <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r      <= h_nxt;
    len_r    <= len_nxt;
    off_r    <= off_nxt;
    p_r      <= p_nxt;
    remain_r <= remain_nxt;
  end

  a_full_idx: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |-> (wr_idx_r == rd_idx_r))
    else $error("ring marked full with differing indices");

  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> out_free)
    else $error("result issued while the output register is occupied");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("sequencer stayed idle after a transfer");

  a_remain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIND) |-> (remain_r <= CNT_W'(SLOTS)))
    else $error("walk counter exceeds the ring size");

endmodule
